// ===== rtl/beacon_ssid_extractor_unit_assert.svh =====
// Assertion helpers shared by the beacon SSID extractor modules.
`ifndef BEACON_SSID_EXTRACTOR_UNIT_ASSERT_SVH
`define BEACON_SSID_EXTRACTOR_UNIT_ASSERT_SVH

// Checked on every clock edge outside reset.
`define BSE_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define BSE_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/bse_pkg.sv =====
`timescale 1ns / 1ps

package bse_pkg;

  localparam int MAX_SSID_BYTES = 32;
  localparam int HDR_BYTES      = 24;
  localparam int FIXED_BYTES    = 12;
  localparam int ENTRY_HDR_BYTES = 6;

  localparam logic [7:0] TAG_SSID   = 8'h00;
  localparam logic [7:0] TAG_VENDOR = 8'hDD;

  // result kinds
  localparam logic [1:0] KIND_BSSID  = 2'd0;
  localparam logic [1:0] KIND_SSID   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // frame status codes
  localparam logic [2:0] ST_BEACON      = 3'd0;
  localparam logic [2:0] ST_TOO_SHORT   = 3'd1;
  localparam logic [2:0] ST_BAD_VERSION = 3'd2;
  localparam logic [2:0] ST_NOT_MGMT    = 3'd3;
  localparam logic [2:0] ST_NOT_BEACON  = 3'd4;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_VENDOR_ID = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 1'b1;

  localparam logic [31:0] VENDOR_ID_RESET = 32'h0050F205;

  // front-to-back queue, depth a power of two
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
  localparam logic [Q_CNT_W-1:0] Q_FULL_CNT = Q_CNT_W'(Q_DEPTH);
  localparam logic [Q_CNT_W-1:0] Q_CNT_STEP = Q_CNT_W'(1);
  localparam logic [Q_PTR_W-1:0] Q_PTR_STEP = Q_PTR_W'(1);

  typedef struct packed {
    logic [7:0]  frame_byte;
    logic        frame_start;
    logic [11:0] frame_length;
  } item_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] payload_byte;
    logic [7:0] ssid_number;
    logic       ssid_end;
    logic [2:0] frame_status;
    logic [7:0] ssid_total;
  } result_t;

  // up to two words caused by one input byte
  typedef struct packed {
    logic    two;
    result_t res0;
    result_t res1;
  } bundle_t;

  typedef struct packed {
    logic [31:0] vendor_id;
    logic        enable;
  } cfg_t;

endpackage

// ===== rtl/bse_parser.sv =====
`timescale 1ns / 1ps

module bse_parser (
  input  logic             clk,
  input  logic             rst,
  input  bse_pkg::cfg_t    cfg,
  input  logic             push,
  input  logic             full,
  input  bse_pkg::item_t   item,
  output logic             wr,
  output bse_pkg::bundle_t wdata
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_HEADER, PH_ELEM_ID, PH_LEN_SSID, PH_LEN_VEND, PH_LEN_OTHER,
    PH_SKIP, PH_SSID_BODY, PH_VEND_ID, PH_VEND_PAD, PH_VEND_COUNT,
    PH_ENTRY_HDR, PH_ENTRY_NAME, PH_DONE
  } phase_t;

  phase_t      phase, phase_next;
  logic [11:0] pos, pos_next;
  logic [11:0] rem, rem_next;
  logic [2:0]  verdict, verdict_next;
  logic [7:0]  elen, elen_next;
  logic [7:0]  eoff, eoff_next;
  logic [31:0] vmatch, vmatch_next;
  logic [8:0]  budget, budget_next;
  logic [7:0]  entries, entries_next;
  logic [5:0]  ent_off, ent_off_next;
  logic [7:0]  name_len, name_len_next;
  logic [7:0]  ssid_cnt, ssid_cnt_next;

  logic           accept;
  logic           active;
  logic [11:0]    left;
  logic [7:0]     b;
  logic           data_put;
  logic           status_put;
  bse_pkg::result_t data_res;
  bse_pkg::result_t status_res;

  function automatic phase_t next_entry(input logic [7:0] ent, input logic [8:0] bud);
    if (ent == 8'd0 || bud < 9'(bse_pkg::ENTRY_HDR_BYTES)) begin
      return PH_SKIP;
    end
    return PH_ENTRY_HDR;
  endfunction

  assign accept = push && !full;
  assign b      = item.frame_byte;
  assign active = accept && (item.frame_start || (phase != PH_IDLE && rem != 12'd0));

  always_comb begin
    logic last;
    phase_next    = phase;
    pos_next      = pos;
    rem_next      = rem;
    verdict_next  = verdict;
    elen_next     = elen;
    eoff_next     = eoff;
    vmatch_next   = vmatch;
    budget_next   = budget;
    entries_next  = entries;
    ent_off_next  = ent_off;
    name_len_next = name_len;
    ssid_cnt_next = ssid_cnt;
    left          = rem;
    last          = 1'b0;
    data_put      = 1'b0;
    status_put    = 1'b0;
    data_res      = '0;
    status_res    = '0;

    if (active) begin
      if (item.frame_start) begin
        left          = (item.frame_length == 12'd0) ? 12'd1 : item.frame_length;
        pos_next      = 12'd0;
        ssid_cnt_next = 8'd0;
        elen_next     = 8'd0;
        eoff_next     = 8'd0;
        vmatch_next   = 32'd0;
        budget_next   = 9'd0;
        entries_next  = 8'd0;
        ent_off_next  = 6'd0;
        name_len_next = 8'd0;
        if (item.frame_length < 12'(bse_pkg::HDR_BYTES)) begin
          verdict_next = bse_pkg::ST_TOO_SHORT;
        end else if (b[1:0] != 2'd0) begin
          verdict_next = bse_pkg::ST_BAD_VERSION;
        end else if (b[3:2] != 2'd0) begin
          verdict_next = bse_pkg::ST_NOT_MGMT;
        end else if (b[7:4] != 4'd8) begin
          verdict_next = bse_pkg::ST_NOT_BEACON;
        end else begin
          verdict_next = bse_pkg::ST_BEACON;
        end
        phase_next = (verdict_next != bse_pkg::ST_BEACON) ? PH_DONE : PH_HEADER;
      end

      case (phase_next)
        PH_HEADER: begin
          if (pos_next >= 12'd16 && pos_next <= 12'd21) begin
            data_put              = 1'b1;
            data_res.result_kind  = bse_pkg::KIND_BSSID;
            data_res.payload_byte = b;
            data_res.ssid_end     = (pos_next == 12'd21);
          end
          if (pos_next == 12'(bse_pkg::HDR_BYTES + bse_pkg::FIXED_BYTES - 1)) begin
            phase_next = PH_ELEM_ID;
          end
        end
        PH_ELEM_ID: begin
          if (left <= 12'd2) begin
            phase_next = PH_DONE;
          end else if (b == bse_pkg::TAG_SSID) begin
            phase_next = PH_LEN_SSID;
          end else if (b == bse_pkg::TAG_VENDOR) begin
            phase_next = PH_LEN_VEND;
          end else begin
            phase_next = PH_LEN_OTHER;
          end
        end
        PH_LEN_SSID, PH_LEN_VEND, PH_LEN_OTHER: begin
          elen_next = b;
          eoff_next = 8'd0;
          if (b == 8'd0) begin
            phase_next = PH_ELEM_ID;
          end else if (phase_next == PH_LEN_SSID) begin
            phase_next = (b <= 8'(bse_pkg::MAX_SSID_BYTES)
                          && {1'b0, left} >= {5'd0, b} + 13'd1) ? PH_SSID_BODY : PH_SKIP;
          end else if (phase_next == PH_LEN_VEND && cfg.enable && b > 8'd4
                       && {1'b0, left} >= {5'd0, b} + 13'd1) begin
            vmatch_next = 32'd0;
            phase_next  = PH_VEND_ID;
          end else begin
            phase_next = PH_SKIP;
          end
        end
        PH_SSID_BODY: begin
          last                  = ({1'b0, eoff} + 9'd1 == {1'b0, elen});
          data_put              = 1'b1;
          data_res.result_kind  = bse_pkg::KIND_SSID;
          data_res.payload_byte = b;
          data_res.ssid_number  = ssid_cnt_next;
          data_res.ssid_end     = last;
          if (last && ssid_cnt_next != 8'hFF) begin
            ssid_cnt_next = ssid_cnt_next + 8'd1;
          end
        end
        PH_VEND_ID: begin
          vmatch_next = {vmatch_next[23:0], b};
          if (eoff == 8'd3) begin
            phase_next = (vmatch_next == cfg.vendor_id && elen >= 8'd6) ? PH_VEND_PAD
                                                                         : PH_SKIP;
          end
        end
        PH_VEND_PAD: begin
          phase_next = PH_VEND_COUNT;
        end
        PH_VEND_COUNT: begin
          entries_next = b;
          budget_next  = {1'b0, elen} - 9'(bse_pkg::ENTRY_HDR_BYTES);
          phase_next   = next_entry(entries_next, budget_next);
          if (phase_next == PH_ENTRY_HDR) begin
            ent_off_next = 6'd0;
          end
        end
        PH_ENTRY_HDR: begin
          if (ent_off < 6'(bse_pkg::ENTRY_HDR_BYTES - 1)) begin
            ent_off_next = ent_off + 6'd1;
          end else if (b > 8'(bse_pkg::MAX_SSID_BYTES)
                       || {1'b0, budget} < 10'(bse_pkg::ENTRY_HDR_BYTES) + {2'd0, b}) begin
            phase_next = PH_SKIP;
          end else begin
            budget_next   = 9'({1'b0, budget} - (10'(bse_pkg::ENTRY_HDR_BYTES) + {2'd0, b}));
            name_len_next = b;
            entries_next  = entries - 8'd1;
            if (b == 8'd0) begin
              phase_next = next_entry(entries_next, budget_next);
              if (phase_next == PH_ENTRY_HDR) begin
                ent_off_next = 6'd0;
              end
            end else begin
              ent_off_next = 6'd0;
              phase_next   = PH_ENTRY_NAME;
            end
          end
        end
        PH_ENTRY_NAME: begin
          last                  = ({3'd0, ent_off} + 9'd1 >= {1'b0, name_len});
          data_put              = 1'b1;
          data_res.result_kind  = bse_pkg::KIND_SSID;
          data_res.payload_byte = b;
          data_res.ssid_number  = ssid_cnt_next;
          data_res.ssid_end     = last;
          if (last) begin
            if (ssid_cnt_next != 8'hFF) begin
              ssid_cnt_next = ssid_cnt_next + 8'd1;
            end
            phase_next = next_entry(entries, budget);
            if (phase_next == PH_ENTRY_HDR) begin
              ent_off_next = 6'd0;
            end
          end else begin
            ent_off_next = ent_off + 6'd1;
          end
        end
        default: begin
        end
      endcase

      // element body byte consumed: step the offset, fall back to the tag at the end
      if (phase == PH_SKIP || phase == PH_SSID_BODY || phase == PH_VEND_ID
          || phase == PH_VEND_PAD || phase == PH_VEND_COUNT || phase == PH_ENTRY_HDR
          || phase == PH_ENTRY_NAME) begin
        if (!item.frame_start) begin
          eoff_next = eoff + 8'd1;
          if (eoff_next >= elen) begin
            phase_next = PH_ELEM_ID;
          end
        end
      end

      pos_next = pos_next + 12'd1;
      rem_next = left - 12'd1;
      if (left == 12'd1) begin
        status_put              = 1'b1;
        status_res.result_kind  = bse_pkg::KIND_STATUS;
        status_res.frame_status = verdict_next;
        status_res.ssid_total   = ssid_cnt_next;
        phase_next              = PH_IDLE;
      end
    end
  end

  always_comb begin
    wr         = active && (data_put || status_put);
    wdata.two  = data_put && status_put;
    wdata.res0 = data_put ? data_res : status_res;
    wdata.res1 = status_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      pos      <= '0;
      rem      <= '0;
      verdict  <= '0;
      elen     <= '0;
      eoff     <= '0;
      vmatch   <= '0;
      budget   <= '0;
      entries  <= '0;
      ent_off  <= '0;
      name_len <= '0;
      ssid_cnt <= '0;
    end else begin
      phase    <= phase_next;
      pos      <= pos_next;
      rem      <= rem_next;
      verdict  <= verdict_next;
      elen     <= elen_next;
      eoff     <= eoff_next;
      vmatch   <= vmatch_next;
      budget   <= budget_next;
      entries  <= entries_next;
      ent_off  <= ent_off_next;
      name_len <= name_len_next;
      ssid_cnt <= ssid_cnt_next;
    end
  end

endmodule

// ===== rtl/bse_queue.sv =====
`timescale 1ns / 1ps
`include "beacon_ssid_extractor_unit_assert.svh"

module bse_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  bse_pkg::bundle_t wdata,
  input  logic             rd,
  output bse_pkg::bundle_t rdata,
  output logic             full,
  output logic             nempty
);

  bse_pkg::bundle_t              slots [bse_pkg::Q_DEPTH];
  logic [bse_pkg::Q_PTR_W-1:0] wr_ptr;
  logic [bse_pkg::Q_PTR_W-1:0] rd_ptr;
  logic [bse_pkg::Q_CNT_W-1:0] count;

  assign full   = (count == bse_pkg::Q_FULL_CNT);
  assign nempty = (count != '0);
  assign rdata  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + bse_pkg::Q_PTR_STEP;
      end
      if (rd) begin
        rd_ptr <= rd_ptr + bse_pkg::Q_PTR_STEP;
      end
      if (wr && !rd) begin
        count <= count + bse_pkg::Q_CNT_STEP;
      end else if (rd && !wr) begin
        count <= count - bse_pkg::Q_CNT_STEP;
      end
    end
  end

  `BSE_ASSERT_ALWAYS(a_reset_clear, clk, rst |=> (count == '0), "queue not cleared by reset")
  `BSE_ASSERT(a_count_bound, clk, rst, count <= bse_pkg::Q_FULL_CNT, "queue count past depth")
  `BSE_ASSERT(a_no_overflow, clk, rst, wr |-> !full, "write into full queue")
  `BSE_ASSERT(a_no_underflow, clk, rst, rd |-> nempty, "read from empty queue")
  `BSE_ASSERT(a_count_up, clk, rst, (wr && !rd) |=> count == $past(count) + bse_pkg::Q_CNT_STEP, "count did not follow write")

endmodule

// ===== rtl/bse_drain.sv =====
`timescale 1ns / 1ps
`include "beacon_ssid_extractor_unit_assert.svh"

module bse_drain (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_nempty,
  input  bse_pkg::bundle_t q_rdata,
  output logic             q_rd,
  input  logic             pop,
  output logic             empty,
  output bse_pkg::result_t result
);

  bse_pkg::bundle_t cur;
  logic             valid;
  logic             second;
  logic             finishing;

  // the held bundle is used up by this pop
  assign finishing = valid && pop && (second || !cur.two);
  assign q_rd      = q_nempty && (!valid || finishing);
  assign empty     = !valid;
  assign result    = second ? cur.res1 : cur.res0;

  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur <= q_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= 1'b0;
      second <= 1'b0;
    end else if (q_rd) begin
      valid  <= 1'b1;
      second <= 1'b0;
    end else if (valid && pop) begin
      if (cur.two && !second) begin
        second <= 1'b1;
      end else begin
        valid  <= 1'b0;
        second <= 1'b0;
      end
    end
  end

  `BSE_ASSERT(a_second_legal, clk, rst, second |-> (valid && cur.two), "second word without pair")
  `BSE_ASSERT(a_pair_advance, clk, rst, (valid && pop && cur.two && !second) |=> (valid && second), "pair not advanced")
  `BSE_ASSERT(a_load_only_free, clk, rst, q_rd |-> (!valid || finishing), "held word overwritten")

endmodule

// ===== rtl/beacon_ssid_extractor_unit.sv =====
`timescale 1ns / 1ps

// channel   | handshake           | word
// ----------+---------------------+------------------------------------------
// input     | push / full         | item   (frame_byte, frame_start, length)
// result    | empty / pop         | result (kind, byte, number, end, status)
// config    | cfg_write           | cfg_index, cfg_data (32 bits)
//
// Each accepted byte yields zero, one or two result words, the second being the
// end-of-frame status; one byte is taken every cycle while full is low.
// A result word reaches the ports once its bundle has passed the queue and the drain's holding register.
// The parser writes a four-entry queue and full rises only when it is full, so a
// stalled reader stops input once five byte bundles wait (four queued, one held).
// Synchronous reset clears all control state and restores the configuration defaults.
module beacon_ssid_extractor_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  bse_pkg::item_t                 item,
  output logic                           empty,
  input  logic                           pop,
  output bse_pkg::result_t               result,
  input  logic                           cfg_write,
  input  logic [bse_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);

  bse_pkg::cfg_t    cfg;
  logic             q_wr;
  bse_pkg::bundle_t q_wdata;
  logic             q_rd;
  bse_pkg::bundle_t q_rdata;
  logic             q_nempty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.vendor_id <= bse_pkg::VENDOR_ID_RESET;
      cfg.enable    <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        bse_pkg::CFG_VENDOR_ID: cfg.vendor_id <= cfg_data;
        bse_pkg::CFG_ENABLE:    cfg.enable    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  bse_parser u_parser (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .push  (push),
    .full  (full),
    .item  (item),
    .wr    (q_wr),
    .wdata (q_wdata)
  );

  bse_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (q_wr),
    .wdata  (q_wdata),
    .rd     (q_rd),
    .rdata  (q_rdata),
    .full   (full),
    .nempty (q_nempty)
  );

  bse_drain u_drain (
    .clk      (clk),
    .rst      (rst),
    .q_nempty (q_nempty),
    .q_rdata  (q_rdata),
    .q_rd     (q_rd),
    .pop      (pop),
    .empty    (empty),
    .result   (result)
  );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import bse_pkg::*;

  localparam logic [7:0] FC_BEACON      = 8'h80;
  localparam logic [7:0] FC_BAD_VER     = 8'h81;
  localparam logic [7:0] FC_DATA        = 8'h88;
  localparam logic [7:0] FC_PROBE_RESP  = 8'h50;
  localparam logic [1:0] FC_VERSION_0   = 2'd0;
  localparam logic [1:0] FC_TYPE_MGMT   = 2'd0;
  localparam logic [3:0] SUBTYPE_BEACON = 4'd8;
  localparam logic [7:0] TAG_RATES      = 8'h01;
  localparam int BSSID_FIRST   = 16;
  localparam int BSSID_LAST    = 21;
  localparam int VEND_ID_LAST  = 3;
  localparam int VEND_HDR_BYTES = 6;
  localparam int MAX_LEN_FIELD = 4095;
  localparam int LONG_SSID_COUNT = 258;
  localparam int DRAIN_SETTLE  = 10;
  localparam int RANDOM_BYTES  = 400;
  localparam int TIMEOUT_NS    = 3_000_000;

  typedef enum logic [3:0] {
    PH_IDLE, PH_HEADER, PH_ELEM_ID, PH_LEN_SSID, PH_LEN_VEND, PH_LEN_OTHER, PH_SKIP,
    PH_SSID_BODY, PH_VEND_ID, PH_VEND_PAD, PH_VEND_COUNT, PH_ENTRY_HDR, PH_ENTRY_NAME,
    PH_DONE
  } phase_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  logic                 full;
  item_t                item = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  result_t              result;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  beacon_ssid_extractor_unit dut (
    .clk, .rst, .push, .full, .item, .empty, .pop, .result, .cfg_write, .cfg_index, .cfg_data
  );

  int         send_idle_pct = 0;
  int         pop_stall_pct = 0;
  int         hold_left = 0;
  int         fail_count = 0;
  result_t    expected_words[$];
  logic [7:0] frame_buf[$];
  int         name_plan[$];

  // parser mirror
  logic [31:0] vendor_id_reg = VENDOR_ID_RESET;
  logic        multi_enable_reg = 1'b1;
  logic [11:0] at_pos = '0;
  logic [11:0] bytes_left = '0;
  phase_t      phase = PH_IDLE;
  logic [2:0]  verdict = '0;
  logic [7:0]  el_len = '0;
  logic [7:0]  el_off = '0;
  logic [31:0] vend_acc = '0;
  logic [8:0]  vend_budget = '0;
  logic [7:0]  entries_todo = '0;
  logic [5:0]  entry_off = '0;
  logic [7:0]  name_len = '0;
  logic [7:0]  ssid_count = '0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void emit_word(logic [1:0] kind, logic [7:0] data, logic [7:0] num,
                                    logic last, logic [2:0] status, logic [7:0] total);
    result_t w;
    w.result_kind  = kind;
    w.payload_byte = data;
    w.ssid_number  = num;
    w.ssid_end     = last;
    w.frame_status = status;
    w.ssid_total   = total;
    expected_words.insert(expected_words.size(), w);
  endfunction

  function automatic void bump_ssid_count();
    if (ssid_count != 8'd255) ssid_count = ssid_count + 8'd1;
  endfunction

  function automatic void next_entry();
    if (entries_todo == 8'd0 || vend_budget < ENTRY_HDR_BYTES) begin
      phase = PH_SKIP;
    end else begin
      phase = PH_ENTRY_HDR;
      entry_off = '0;
    end
  endfunction

  function automatic void advance_body();
    el_off = el_off + 8'd1;
    if (el_off >= el_len) phase = PH_ELEM_ID;
  endfunction

  function automatic void predict_byte(item_t it);
    logic [7:0]  b;
    logic [11:0] left;
    logic [11:0] pos;
    logic        last;
    b = it.frame_byte;
    if (it.frame_start) begin
      left = (it.frame_length == 12'd0) ? 12'd1 : it.frame_length;
      at_pos = '0;
      ssid_count = '0;
      el_len = '0;
      el_off = '0;
      vend_acc = '0;
      vend_budget = '0;
      entries_todo = '0;
      entry_off = '0;
      name_len = '0;
      if (it.frame_length < HDR_BYTES) verdict = ST_TOO_SHORT;
      else if (b[1:0] != FC_VERSION_0) verdict = ST_BAD_VERSION;
      else if (b[3:2] != FC_TYPE_MGMT) verdict = ST_NOT_MGMT;
      else if (b[7:4] != SUBTYPE_BEACON) verdict = ST_NOT_BEACON;
      else verdict = ST_BEACON;
      phase = (verdict == ST_BEACON) ? PH_HEADER : PH_DONE;
    end else begin
      if (phase == PH_IDLE || bytes_left == 12'd0) return;
      left = bytes_left;
    end
    pos = at_pos;

    case (phase)
      PH_HEADER: begin
        if (pos >= BSSID_FIRST && pos <= BSSID_LAST)
          emit_word(KIND_BSSID, b, '0, pos == BSSID_LAST, '0, '0);
        if (pos == HDR_BYTES + FIXED_BYTES - 1) phase = PH_ELEM_ID;
      end
      PH_ELEM_ID: begin
        if (left <= 12'd2) phase = PH_DONE;
        else if (b == TAG_SSID) phase = PH_LEN_SSID;
        else if (b == TAG_VENDOR) phase = PH_LEN_VEND;
        else phase = PH_LEN_OTHER;
      end
      PH_LEN_SSID, PH_LEN_VEND, PH_LEN_OTHER: begin
        el_len = b;
        el_off = '0;
        if (b == 8'd0) begin
          phase = PH_ELEM_ID;
        end else if (phase == PH_LEN_SSID) begin
          phase = (b <= MAX_SSID_BYTES && left >= b + 1) ? PH_SSID_BODY : PH_SKIP;
        end else if (phase == PH_LEN_VEND && multi_enable_reg && b > 4 && left >= b + 1) begin
          vend_acc = '0;
          phase = PH_VEND_ID;
        end else begin
          phase = PH_SKIP;
        end
      end
      PH_SKIP: advance_body();
      PH_SSID_BODY: begin
        last = (el_off + 1 == el_len);
        emit_word(KIND_SSID, b, ssid_count, last, '0, '0);
        if (last) bump_ssid_count();
        advance_body();
      end
      PH_VEND_ID: begin
        vend_acc = {vend_acc[23:0], b};
        if (el_off == VEND_ID_LAST)
          phase = (vend_acc == vendor_id_reg && el_len >= VEND_HDR_BYTES) ? PH_VEND_PAD : PH_SKIP;
        advance_body();
      end
      PH_VEND_PAD: begin
        phase = PH_VEND_COUNT;
        advance_body();
      end
      PH_VEND_COUNT: begin
        entries_todo = b;
        vend_budget = 9'(el_len - VEND_HDR_BYTES);
        next_entry();
        advance_body();
      end
      PH_ENTRY_HDR: begin
        if (entry_off < ENTRY_HDR_BYTES - 1) begin
          entry_off = entry_off + 6'd1;
        end else if (b > MAX_SSID_BYTES || vend_budget < ENTRY_HDR_BYTES + b) begin
          phase = PH_SKIP;
        end else begin
          vend_budget = 9'(vend_budget - (ENTRY_HDR_BYTES + b));
          name_len = b;
          entries_todo = entries_todo - 8'd1;
          if (b == 8'd0) begin
            next_entry();
          end else begin
            entry_off = '0;
            phase = PH_ENTRY_NAME;
          end
        end
        advance_body();
      end
      PH_ENTRY_NAME: begin
        last = (entry_off + 1 >= name_len);
        emit_word(KIND_SSID, b, ssid_count, last, '0, '0);
        if (last) begin
          bump_ssid_count();
          next_entry();
        end else begin
          entry_off = entry_off + 6'd1;
        end
        advance_body();
      end
      default: ;
    endcase

    at_pos = pos + 12'd1;
    bytes_left = left - 12'd1;
    if (left == 12'd1) begin
      emit_word(KIND_STATUS, '0, '0, 1'b0, verdict, ssid_count);
      phase = PH_IDLE;
    end
  endfunction

  function automatic void append_byte(logic [7:0] v);
    frame_buf.insert(frame_buf.size(), v);
  endfunction

  // frame control plus the rest of the header and the fixed fields
  function automatic void start_header(logic [7:0] fc);
    frame_buf.delete();
    append_byte(fc);
    repeat (HDR_BYTES + FIXED_BYTES - 1) append_byte(8'($urandom));
  endfunction

  function automatic void add_element(logic [7:0] tag, int len);
    append_byte(tag);
    append_byte(8'(len));
    repeat (len) append_byte(8'($urandom));
  endfunction

  // entries come from name_plan; len_adjust moves the length byte off the body size
  function automatic void add_multi_ssid(logic [31:0] id, logic [7:0] count, int len_adjust);
    logic [7:0] body[$];
    int         total;
    for (int i = 3; i >= 0; i--) body.insert(body.size(), id[8*i +: 8]);
    body.insert(body.size(), 8'($urandom));
    body.insert(body.size(), count);
    foreach (name_plan[i]) begin
      repeat (ENTRY_HDR_BYTES - 1) body.insert(body.size(), 8'($urandom));
      body.insert(body.size(), 8'(name_plan[i]));
      repeat (name_plan[i]) body.insert(body.size(), 8'($urandom));
    end
    total = body.size() + len_adjust;
    if (total > 255) total = 255;
    if (total < 0) total = 0;
    append_byte(TAG_VENDOR);
    append_byte(8'(total));
    foreach (body[i]) append_byte(body[i]);
    if (len_adjust > 0) repeat (len_adjust) append_byte(8'($urandom));
  endfunction

  function automatic int build_random_frame();
    int         n_elem;
    int         pick;
    int         flen;
    int         len;
    logic [7:0] fc;
    fc = ($urandom_range(99) < 85) ? FC_BEACON : 8'($urandom);
    start_header(fc);
    n_elem = $urandom_range(0, 4);
    repeat (n_elem) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 12);
        add_element(TAG_SSID, len);
      end else if (pick < 75) begin
        name_plan.delete();
        repeat ($urandom_range(0, 3))
          name_plan.insert(name_plan.size(),
                           ($urandom_range(9) == 0) ? $urandom_range(0, 40)
                                                    : $urandom_range(1, 10));
        add_multi_ssid(($urandom_range(9) == 0) ? $urandom : vendor_id_reg,
                       ($urandom_range(4) == 0) ? 8'($urandom_range(0, 4))
                                                : 8'(name_plan.size()),
                       ($urandom_range(4) == 0) ? int'($urandom_range(0, 8)) - 4 : 0);
      end else begin
        add_element(8'($urandom), $urandom_range(0, 16));
      end
    end
    flen = frame_buf.size() + $urandom_range(0, 3);
    pick = $urandom_range(99);
    if (pick < 10) flen = $urandom_range(1, 30);
    else if (pick < 20) flen = frame_buf.size() - int'($urandom_range(1, 10));
    return flen;
  endfunction

  task automatic offer_byte(logic [7:0] data, logic first, logic [11:0] flen);
    item_t it;
    it.frame_byte   = data;
    it.frame_start  = first;
    it.frame_length = first ? flen : 12'($urandom);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    predict_byte(it);
  endtask

  // bytes past the end of frame_buf are random fill
  task automatic transmit_frame(int flen, int nsend = -1);
    if (nsend < 0) nsend = (flen == 0) ? 1 : flen;
    for (int i = 0; i < nsend; i++)
      offer_byte(i < frame_buf.size() ? frame_buf[i] : 8'($urandom), i == 0, 12'(flen));
  endtask

  task automatic wait_drained(int settle);
    push <= 1'b0;
    do @(posedge clk); while (expected_words.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    wait_drained(DRAIN_SETTLE);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_VENDOR_ID) vendor_id_reg = data;
    else multi_enable_reg = data[0];
  endtask

  task automatic test_frame_control();
    offer_byte(8'($urandom), 1'b0, '0);   // no frame open yet: dropped
    frame_buf.delete();
    transmit_frame(0);
    transmit_frame(1);
    start_header(FC_BEACON);
    transmit_frame(HDR_BYTES - 1);
    start_header(FC_BAD_VER);
    transmit_frame(HDR_BYTES);
    start_header(FC_DATA);
    transmit_frame(HDR_BYTES);
    start_header(FC_PROBE_RESP);
    transmit_frame(HDR_BYTES);
    start_header(FC_BEACON);
    transmit_frame(HDR_BYTES + FIXED_BYTES);
    offer_byte(8'($urandom), 1'b0, '0);   // frame closed: dropped
  endtask

  task automatic test_ssid_elements();
    start_header(FC_BEACON);
    add_element(TAG_SSID, 1);
    add_element(TAG_SSID, MAX_SSID_BYTES);
    add_element(TAG_SSID, 0);
    add_element(TAG_SSID, MAX_SSID_BYTES + 1);
    add_element(TAG_RATES, 4);
    add_element(TAG_SSID, 3);
    transmit_frame(frame_buf.size() + 2);   // two-byte tail ends the walk
    start_header(FC_BEACON);
    add_element(TAG_SSID, 10);
    transmit_frame(frame_buf.size() - 4);   // SSID runs past the frame end
  endtask

  task automatic test_multi_ssid();
    start_header(FC_BEACON);
    name_plan = '{5, 0, MAX_SSID_BYTES};
    add_multi_ssid(vendor_id_reg, 8'd3, 0);
    name_plan = '{4, MAX_SSID_BYTES + 1, 3};
    add_multi_ssid(vendor_id_reg, 8'd3, 0);
    name_plan = '{3, 3};
    add_multi_ssid(vendor_id_reg, 8'd1, 0);
    name_plan = '{4};
    add_multi_ssid(vendor_id_reg, 8'd0, 0);
    name_plan = '{6};
    add_multi_ssid(vendor_id_reg ^ 32'h1, 8'd1, 0);
    add_element(TAG_VENDOR, 5);
    add_element(TAG_VENDOR, 4);
    transmit_frame(frame_buf.size());
    // second name overruns the element
    start_header(FC_BEACON);
    name_plan = '{8, 8};
    add_multi_ssid(vendor_id_reg, 8'd2, -4);
    transmit_frame(frame_buf.size());
    write_reg(CFG_ENABLE, 32'd0);
    start_header(FC_BEACON);
    name_plan = '{5};
    add_multi_ssid(vendor_id_reg, 8'd1, 0);
    transmit_frame(frame_buf.size());
    write_reg(CFG_ENABLE, 32'd1);
  endtask

  task automatic test_restart();
    start_header(FC_BEACON);
    add_element(TAG_SSID, 12);
    transmit_frame(frame_buf.size(), HDR_BYTES + FIXED_BYTES + 5);
    start_header(FC_BEACON);
    add_element(TAG_SSID, 2);
    transmit_frame(frame_buf.size());
  endtask

  // enough one-byte SSIDs to saturate the counters, then a cut-off frame
  // of the largest length
  task automatic test_long_frame();
    start_header(FC_BEACON);
    repeat (LONG_SSID_COUNT) add_element(TAG_SSID, 1);
    transmit_frame(frame_buf.size());
    start_header(FC_BEACON);
    transmit_frame(MAX_LEN_FIELD, HDR_BYTES + FIXED_BYTES + 4);
  endtask

  task automatic test_backpressure();
    start_header(FC_BEACON);
    repeat (8) add_element(TAG_SSID, $urandom_range(4, 12));
    hold_left = 300;
    transmit_frame(frame_buf.size());
    wait_drained(0);
    start_header(FC_BEACON);
    add_element(TAG_SSID, 6);
    transmit_frame(frame_buf.size());
  endtask

  task automatic run_random_traffic(int budget);
    int   sent;
    int   flen;
    int   pick;
    int   cut;
    logic dangling;
    sent = 0;
    dangling = 1'b0;
    while (sent < budget || dangling) begin
      pick = $urandom_range(99);
      if (pick < 10) repeat ($urandom_range(1, 4)) offer_byte(8'($urandom), 1'b0, '0);
      flen = build_random_frame();
      if (pick >= 90 && sent < budget) begin
        cut = $urandom_range(1, flen);
        transmit_frame(flen, cut);
        sent += cut;
        dangling = 1'b1;
      end else begin
        transmit_frame(flen);
        sent += flen;
        dangling = 1'b0;
      end
    end
  endtask

  task automatic test_random_traffic();
    write_reg(CFG_VENDOR_ID, VENDOR_ID_RESET);
    write_reg(CFG_ENABLE, 32'd1);
    send_idle_pct = 0;
    pop_stall_pct = 0;
    run_random_traffic(RANDOM_BYTES / 4);
    write_reg(CFG_VENDOR_ID, '1);
    send_idle_pct = 58;
    pop_stall_pct = 0;
    run_random_traffic(RANDOM_BYTES / 4);
    write_reg(CFG_VENDOR_ID, '0);
    write_reg(CFG_ENABLE, {31'($urandom), 1'b0});
    send_idle_pct = 0;
    pop_stall_pct = 58;
    run_random_traffic(RANDOM_BYTES / 4);
    write_reg(CFG_VENDOR_ID, $urandom);
    write_reg(CFG_ENABLE, {31'($urandom), 1'b1});
    send_idle_pct = 20;
    pop_stall_pct = 20;
    run_random_traffic(RANDOM_BYTES / 4);
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // result side: compare each popped word, then pick next cycle's pop
  always @(posedge clk) begin : result_side
    result_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word: kind %0d byte %0h", result.result_kind, result.payload_byte);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          check_field("result_kind", want.result_kind, result.result_kind);
          check_field("payload_byte", want.payload_byte, result.payload_byte);
          check_field("ssid_number", want.ssid_number, result.ssid_number);
          check_field("ssid_end", want.ssid_end, result.ssid_end);
          check_field("frame_status", want.frame_status, result.frame_status);
          check_field("ssid_total", want.ssid_total, result.ssid_total);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= pop_stall_pct);
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_frame_control();
    test_ssid_elements();
    test_multi_ssid();
    test_restart();
    test_long_frame();
    test_backpressure();
    test_random_traffic();
    wait_drained(20);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

endmodule
